### hw/rtl/qbtm_pkg.sv
// Shared constants and types of the quad barycentric texel mapper.
package qbtm_pkg;

    // Defaults of the top-level parameters
    localparam int SCREEN_W_DEF  = 1024;
    localparam int SCREEN_H_DEF  = 1024;
    localparam int TEX_W_DEF     = 256;
    localparam int TEX_H_DEF     = 256;
    localparam int FRAC_BITS_DEF = 16;

    // Fixed field and datapath widths
    localparam int CW      = 13;        // corner coordinate
    localparam int PIXW    = 10;        // pixel coordinate
    localparam int EW      = 14;        // edge vector component
    localparam int WW      = 15;        // pixel minus origin
    localparam int PW      = EW + WW;   // one cross product term
    localparam int XW      = PW + 1;    // cross product difference
    localparam int DW      = 28;        // divider numerator, denominator, remainder
    localparam int BARY_W  = 17;
    localparam int SRC_W   = 8;
    localparam int ADDR_W  = 5;
    localparam int IN_W    = 24;
    localparam int OUT_W   = 56;
    localparam int USER_W  = 2;

    // Cycles for the triangle setup to settle after a corner write
    localparam logic [1:0] SETTLE = 2'd3;

    // Register indexes of the configuration port
    typedef enum logic [2:0] {
        REG_C0X, REG_C0Y, REG_C1X, REG_C1Y,
        REG_C2X, REG_C2Y, REG_C3X, REG_C3Y
    } qbtm_reg_t;

    // Sideband that travels with an item through the divider
    typedef struct packed {
        logic valid;
        logic hit;
        logic tri_sel;
    } qbtm_side_t;

endpackage

### hw/rtl/qbtm_frac_div.sv
// Pipelined restoring divider giving two fractions of a common denominator.
module qbtm_frac_div #(
    parameter int FRAC_BITS = qbtm_pkg::FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  qbtm_pkg::qbtm_side_t      side_in,
    input  logic [qbtm_pkg::DW-1:0]   num_u,
    input  logic [qbtm_pkg::DW-1:0]   num_v,
    input  logic [qbtm_pkg::DW-1:0]   den,
    output qbtm_pkg::qbtm_side_t      side_out,
    output logic [FRAC_BITS:0]        quo_u,
    output logic [FRAC_BITS:0]        quo_v
);

    localparam int QW = FRAC_BITS + 1;
    localparam int NS = FRAC_BITS + 1;
    localparam int DW = qbtm_pkg::DW;

    qbtm_pkg::qbtm_side_t side_reg [NS];
    logic [DW-1:0]        ru_reg   [NS];
    logic [DW-1:0]        rv_reg   [NS];
    logic [DW-1:0]        d_reg    [NS];
    logic [QW-1:0]        qu_reg   [NS];
    logic [QW-1:0]        qv_reg   [NS];

    // One quotient bit per stage
    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        logic [DW:0]          ru_in;
        logic [DW:0]          rv_in;
        logic [DW-1:0]        d_in;
        logic [QW-1:0]        qu_in;
        logic [QW-1:0]        qv_in;
        qbtm_pkg::qbtm_side_t s_in;
        logic                 bit_u;
        logic                 bit_v;
        logic [DW:0]          ru_diff;
        logic [DW:0]          rv_diff;
        logic [DW-1:0]        ru_next;
        logic [DW-1:0]        rv_next;
        logic [QW-1:0]        qu_next;
        logic [QW-1:0]        qv_next;

        if (k == 0)
        begin : g_first
            assign ru_in = {1'b0, num_u};
            assign rv_in = {1'b0, num_v};
            assign d_in  = den;
            assign qu_in = '0;
            assign qv_in = '0;
            assign s_in  = side_in;
        end
        else
        begin : g_next
            assign ru_in = {ru_reg[k-1], 1'b0};
            assign rv_in = {rv_reg[k-1], 1'b0};
            assign d_in  = d_reg[k-1];
            assign qu_in = qu_reg[k-1];
            assign qv_in = qv_reg[k-1];
            assign s_in  = side_reg[k-1];
        end

        // Compare and subtract where the shifted remainder reaches the divisor
        always_comb
        begin
            bit_u   = (ru_in >= {1'b0, d_in});
            bit_v   = (rv_in >= {1'b0, d_in});
            ru_diff = bit_u ? (ru_in - {1'b0, d_in}) : ru_in;
            rv_diff = bit_v ? (rv_in - {1'b0, d_in}) : rv_in;
            ru_next = ru_diff[DW-1:0];
            rv_next = rv_diff[DW-1:0];
            qu_next = {qu_in[QW-2:0], bit_u};
            qv_next = {qv_in[QW-2:0], bit_v};
        end

        // Advance the stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                side_reg[k] <= '0;
            end
            else if (en)
            begin
                side_reg[k] <= s_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ru_reg[k] <= ru_next;
                rv_reg[k] <= rv_next;
                d_reg[k]  <= d_in;
                qu_reg[k] <= qu_next;
                qv_reg[k] <= qv_next;
            end
        end
    end

    assign side_out = side_reg[NS-1];
    assign quo_u    = qu_reg[NS-1];
    assign quo_v    = qv_reg[NS-1];

endmodule

### hw/rtl/quad_barycentric_texel_mapper_unit.sv
// Top level of the quad barycentric texel mapper: configuration, setup and pixel pipeline.
//
// Takes one pixel per clock while s_tready is high and returns one result per pixel. The
// pixel path has FRAC_BITS + 7 register stages (23 at the defaults); the depth is set by
// the divider, which resolves one quotient bit per stage for both weights at once. The
// pipeline stalls as a whole when the result register is held. After reset and after
// every corner write s_tready stays low while the triangle setup settles. Each triangle
// is tested with exact cross products, so a degenerate triangle never hits and a miss
// returns all zeros.
module quad_barycentric_texel_mapper_unit #(
    parameter int SCREEN_W  = qbtm_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H  = qbtm_pkg::SCREEN_H_DEF,
    parameter int TEX_W     = qbtm_pkg::TEX_W_DEF,
    parameter int TEX_H     = qbtm_pkg::TEX_H_DEF,
    parameter int FRAC_BITS = qbtm_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [qbtm_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // pixel_x[9:0], pixel_y[19:10], zero pad
    input  logic [qbtm_pkg::IN_W-1:0]     s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // bary_u[16:0], bary_v[33:17], src_x[41:34], src_y[49:42], zero pad
    output logic [qbtm_pkg::OUT_W-1:0]    m_tdata,
    // hit[0], which_triangle[1]
    output logic [qbtm_pkg::USER_W-1:0]   m_tuser
);

    localparam int CW     = qbtm_pkg::CW;
    localparam int EW     = qbtm_pkg::EW;
    localparam int WW     = qbtm_pkg::WW;
    localparam int PW     = qbtm_pkg::PW;
    localparam int XW     = qbtm_pkg::XW;
    localparam int DW     = qbtm_pkg::DW;
    localparam int PIXW   = qbtm_pkg::PIXW;
    localparam int BARY_W = qbtm_pkg::BARY_W;
    localparam int SRC_W  = qbtm_pkg::SRC_W;
    localparam int QW     = FRAC_BITS + 1;
    localparam int TXB    = $clog2(TEX_W);
    localparam int TYB    = $clog2(TEX_H);
    localparam int MXW    = QW + TXB;
    localparam int MYW    = QW + TYB;

    localparam logic [CW-1:0]  SCR_W_L = CW'(SCREEN_W);
    localparam logic [CW-1:0]  SCR_H_L = CW'(SCREEN_H);
    localparam logic [TXB-1:0] TXM     = TXB'(TEX_W - 1);
    localparam logic [TYB-1:0] TYM     = TYB'(TEX_H - 1);
    localparam logic [QW-1:0]  ONE     = {1'b1, {FRAC_BITS{1'b0}}};

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    logic                   wr_en;
    qbtm_pkg::qbtm_reg_t    cfg_idx;
    logic signed [CW-1:0]   corner_x_reg [4];
    logic signed [CW-1:0]   corner_y_reg [4];
    logic signed [CW-1:0]   rd_val;
    logic [1:0]             settle_reg;
    logic [1:0]             settle_next;

    assign wr_en   = psel & penable & pwrite;
    assign cfg_idx = qbtm_pkg::qbtm_reg_t'(paddr[4:2]);
    assign pready  = 1'b1;

    // Write the corner registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_x_reg[0] <= 13'sd0;
            corner_y_reg[0] <= 13'sd0;
            corner_x_reg[1] <= 13'sd1023;
            corner_y_reg[1] <= 13'sd0;
            corner_x_reg[2] <= 13'sd0;
            corner_y_reg[2] <= 13'sd1023;
            corner_x_reg[3] <= 13'sd1023;
            corner_y_reg[3] <= 13'sd1023;
        end
        else if (wr_en)
        begin
            unique case (cfg_idx)
                qbtm_pkg::REG_C0X: corner_x_reg[0] <= pwdata[CW-1:0];
                qbtm_pkg::REG_C0Y: corner_y_reg[0] <= pwdata[CW-1:0];
                qbtm_pkg::REG_C1X: corner_x_reg[1] <= pwdata[CW-1:0];
                qbtm_pkg::REG_C1Y: corner_y_reg[1] <= pwdata[CW-1:0];
                qbtm_pkg::REG_C2X: corner_x_reg[2] <= pwdata[CW-1:0];
                qbtm_pkg::REG_C2Y: corner_y_reg[2] <= pwdata[CW-1:0];
                qbtm_pkg::REG_C3X: corner_x_reg[3] <= pwdata[CW-1:0];
                qbtm_pkg::REG_C3Y: corner_y_reg[3] <= pwdata[CW-1:0];
            endcase
        end
    end

    // Read back, sign extended
    always_comb
    begin
        unique case (cfg_idx)
            qbtm_pkg::REG_C0X: rd_val = corner_x_reg[0];
            qbtm_pkg::REG_C0Y: rd_val = corner_y_reg[0];
            qbtm_pkg::REG_C1X: rd_val = corner_x_reg[1];
            qbtm_pkg::REG_C1Y: rd_val = corner_y_reg[1];
            qbtm_pkg::REG_C2X: rd_val = corner_x_reg[2];
            qbtm_pkg::REG_C2Y: rd_val = corner_y_reg[2];
            qbtm_pkg::REG_C3X: rd_val = corner_x_reg[3];
            qbtm_pkg::REG_C3Y: rd_val = corner_y_reg[3];
        endcase
        prdata = {{(32 - CW){rd_val[CW-1]}}, rd_val};
    end

    // Hold off pixels while the setup settles
    always_comb
    begin
        if (wr_en)
            settle_next = qbtm_pkg::SETTLE;
        else if (settle_reg != 2'd0)
            settle_next = settle_reg - 2'd1;
        else
            settle_next = settle_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            settle_reg <= qbtm_pkg::SETTLE;
        else
            settle_reg <= settle_next;
    end

    // ------------------------------------------------------------------
    // Triangle setup: triangle 0 has origin corner0, triangle 1 corner3
    // ------------------------------------------------------------------
    logic signed [EW-1:0] e0x_reg [2];
    logic signed [EW-1:0] e0y_reg [2];
    logic signed [EW-1:0] e1x_reg [2];
    logic signed [EW-1:0] e1y_reg [2];
    logic signed [PW-1:0] ca_reg  [2];
    logic signed [PW-1:0] cb_reg  [2];
    logic [DW-1:0]        cabs_reg [2];
    logic                 cneg_reg [2];
    logic                 cdeg_reg [2];
    logic signed [XW-1:0] cross_next [2];
    logic signed [XW-1:0] cmag_next  [2];

    always_comb
    begin
        for (int t = 0; t < 2; t++)
        begin
            cross_next[t] = XW'(ca_reg[t]) - XW'(cb_reg[t]);
            cmag_next[t]  = cross_next[t][XW-1] ? -cross_next[t] : cross_next[t];
        end
    end

    // Recompute edges, cross terms and the determinant every cycle
    always_ff @(posedge clk)
    begin
        for (int t = 0; t < 2; t++)
        begin
            e0x_reg[t]  <= EW'(corner_x_reg[2]) - EW'(corner_x_reg[t * 3]);
            e0y_reg[t]  <= EW'(corner_y_reg[2]) - EW'(corner_y_reg[t * 3]);
            e1x_reg[t]  <= EW'(corner_x_reg[1]) - EW'(corner_x_reg[t * 3]);
            e1y_reg[t]  <= EW'(corner_y_reg[1]) - EW'(corner_y_reg[t * 3]);
            ca_reg[t]   <= PW'(e0x_reg[t]) * PW'(e1y_reg[t]);
            cb_reg[t]   <= PW'(e0y_reg[t]) * PW'(e1x_reg[t]);
            cneg_reg[t] <= cross_next[t][XW-1];
            cdeg_reg[t] <= (cross_next[t] == '0);
            cabs_reg[t] <= cmag_next[t][DW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Pixel pipeline, advanced as a whole
    // ------------------------------------------------------------------
    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en && (settle_reg == 2'd0);

    // Stage 1: pixel relative to each origin
    logic                 p1_valid_reg;
    logic                 p1_off_reg;
    logic signed [WW-1:0] wx_reg [2];
    logic signed [WW-1:0] wy_reg [2];
    logic [PIXW-1:0]      px;
    logic [PIXW-1:0]      py;

    assign px = s_tdata[PIXW-1:0];
    assign py = s_tdata[2*PIXW-1:PIXW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else if (en)
            p1_valid_reg <= s_tvalid && s_tready;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_off_reg <= (CW'(px) >= SCR_W_L) || (CW'(py) >= SCR_H_L);
            for (int t = 0; t < 2; t++)
            begin
                wx_reg[t] <= signed'(WW'(px)) - WW'(corner_x_reg[t * 3]);
                wy_reg[t] <= signed'(WW'(py)) - WW'(corner_y_reg[t * 3]);
            end
        end
    end

    // Stage 2: cross product terms
    logic                 p2_valid_reg;
    logic                 p2_off_reg;
    logic signed [PW-1:0] ua_reg [2];
    logic signed [PW-1:0] ub_reg [2];
    logic signed [PW-1:0] va_reg [2];
    logic signed [PW-1:0] vb_reg [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_valid_reg <= 1'b0;
        else if (en)
            p2_valid_reg <= p1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_off_reg <= p1_off_reg;
            for (int t = 0; t < 2; t++)
            begin
                ua_reg[t] <= PW'(wx_reg[t]) * PW'(e1y_reg[t]);
                ub_reg[t] <= PW'(wy_reg[t]) * PW'(e1x_reg[t]);
                va_reg[t] <= PW'(e0x_reg[t]) * PW'(wy_reg[t]);
                vb_reg[t] <= PW'(e0y_reg[t]) * PW'(wx_reg[t]);
            end
        end
    end

    // Stage 3: numerators, turned to the sign of the determinant
    logic                 p3_valid_reg;
    logic                 p3_off_reg;
    logic signed [XW-1:0] cu_reg [2];
    logic signed [XW-1:0] cv_reg [2];
    logic signed [XW-1:0] cu_next [2];
    logic signed [XW-1:0] cv_next [2];

    always_comb
    begin
        for (int t = 0; t < 2; t++)
        begin
            cu_next[t] = XW'(ua_reg[t]) - XW'(ub_reg[t]);
            cv_next[t] = XW'(va_reg[t]) - XW'(vb_reg[t]);
            if (cneg_reg[t])
            begin
                cu_next[t] = -cu_next[t];
                cv_next[t] = -cv_next[t];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p3_valid_reg <= 1'b0;
        else if (en)
            p3_valid_reg <= p2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p3_off_reg <= p2_off_reg;
            for (int t = 0; t < 2; t++)
            begin
                cu_reg[t] <= cu_next[t];
                cv_reg[t] <= cv_next[t];
            end
        end
    end

    // Stage 4: inside test, pick the first triangle that holds the pixel
    qbtm_pkg::qbtm_side_t p4_side_reg;
    qbtm_pkg::qbtm_side_t p4_side_next;
    logic [DW-1:0]        p4_nu_reg;
    logic [DW-1:0]        p4_nv_reg;
    logic [DW-1:0]        p4_den_reg;
    logic                 in_tri [2];
    logic signed [XW:0]   uv_sum [2];
    logic                 pick;

    always_comb
    begin
        for (int t = 0; t < 2; t++)
        begin
            uv_sum[t] = (XW + 1)'(cu_reg[t]) + (XW + 1)'(cv_reg[t]);
            in_tri[t] = !cdeg_reg[t] && !cu_reg[t][XW-1] && !cv_reg[t][XW-1] &&
                        (uv_sum[t] <= signed'((XW + 1)'(cabs_reg[t])));
        end
        pick                 = !in_tri[0];
        p4_side_next.valid   = p3_valid_reg;
        p4_side_next.hit     = !p3_off_reg && (in_tri[0] || in_tri[1]);
        p4_side_next.tri_sel = p4_side_next.hit && pick;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p4_side_reg <= '0;
        else if (en)
            p4_side_reg <= p4_side_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p4_nu_reg  <= cu_reg[pick][DW-1:0];
            p4_nv_reg  <= cv_reg[pick][DW-1:0];
            p4_den_reg <= cabs_reg[pick];
        end
    end

    // Divider stages
    qbtm_pkg::qbtm_side_t dv_side;
    logic [QW-1:0]        dv_qu;
    logic [QW-1:0]        dv_qv;

    qbtm_frac_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .side_in  (p4_side_reg),
        .num_u    (p4_nu_reg),
        .num_v    (p4_nv_reg),
        .den      (p4_den_reg),
        .side_out (dv_side),
        .quo_u    (dv_qu),
        .quo_v    (dv_qv)
    );

    // Texel stage: scale the weights onto the texture
    qbtm_pkg::qbtm_side_t tx_side_reg;
    logic [QW-1:0]        tx_bu_reg;
    logic [QW-1:0]        tx_bv_reg;
    logic [MXW-1:0]       tx_px_reg;
    logic [MYW-1:0]       tx_py_reg;
    logic [QW-1:0]        mul_x;
    logic [QW-1:0]        mul_y;

    always_comb
    begin
        if (dv_side.tri_sel)
        begin
            mul_x = ONE - dv_qu;
            mul_y = ONE - dv_qv;
        end
        else
        begin
            mul_x = dv_qv;
            mul_y = dv_qu;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tx_side_reg <= '0;
        else if (en)
            tx_side_reg <= dv_side;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tx_bu_reg <= dv_qu;
            tx_bv_reg <= dv_qv;
            tx_px_reg <= MXW'(mul_x) * MXW'(TXM);
            tx_py_reg <= MYW'(mul_y) * MYW'(TYM);
        end
    end

    // Result register: truncate the fields, zero them on a miss
    logic [qbtm_pkg::OUT_W-1:0]  out_data_reg;
    logic [qbtm_pkg::OUT_W-1:0]  out_data_next;
    logic [qbtm_pkg::USER_W-1:0] out_user_reg;
    logic [qbtm_pkg::USER_W-1:0] out_user_next;
    logic [QW+BARY_W-1:0]        bu_ext;
    logic [QW+BARY_W-1:0]        bv_ext;
    logic [MXW+SRC_W-1:0]        sx_ext;
    logic [MYW+SRC_W-1:0]        sy_ext;

    always_comb
    begin
        bu_ext = (QW + BARY_W)'(tx_bu_reg);
        bv_ext = (QW + BARY_W)'(tx_bv_reg);
        sx_ext = (MXW + SRC_W)'(tx_px_reg) >> FRAC_BITS;
        sy_ext = (MYW + SRC_W)'(tx_py_reg) >> FRAC_BITS;
        out_data_next = '0;
        out_user_next = '0;
        if (tx_side_reg.hit)
        begin
            out_data_next = qbtm_pkg::OUT_W'({sy_ext[SRC_W-1:0], sx_ext[SRC_W-1:0],
                                              bv_ext[BARY_W-1:0], bu_ext[BARY_W-1:0]});
            out_user_next = {tx_side_reg.tri_sel, 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= tx_side_reg.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0 && !m_tuser[1]))
        else $error("miss transaction carries non-zero fields");

    a_settle_block: assert property (@(posedge clk) disable iff (!rst_n)
        (settle_reg != 2'd0) |-> !s_tready)
        else $error("pixel taken while setup is settling");

    a_write_settle: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (settle_reg == qbtm_pkg::SETTLE))
        else $error("corner write did not restart setup");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> out_valid_reg)
        else $error("stalled result dropped");

endmodule
